// ===== hdl/fen_position_parser_assert.svh =====
// Assertion macros for the FEN parser modules, included by the emitter.
`ifndef FEN_POSITION_PARSER_ASSERT_SVH
`define FEN_POSITION_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that holds at every clock edge outside reset.
`define FPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fen parser assertion failed");
// Condition that must never be true outside reset.
`define FPP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fen parser forbidden condition seen");
`else
`define FPP_ASSERT(lbl, prop)
`define FPP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/fpp_pkg.sv =====
// Types, constants and helper functions of the FEN position parser.
`default_nettype none
package fpp_pkg;

  localparam int unsigned NUM_BOARDS = 14;

  localparam logic [3:0] WHITE_BOARD = 4'd12;
  localparam logic [3:0] BLACK_BOARD = 4'd13;
  localparam logic [3:0] LAST_BOARD  = 4'd13;

  localparam logic [7:0] START_SQUARE = 8'd56;
  localparam logic [6:0] NO_SQUARE    = 7'd64;
  localparam logic [2:0] FIELD_MAX    = 3'd4;
  localparam logic [7:0] ROW_STEP     = 8'd16;

  // Field of the FEN string being parsed
  localparam logic [2:0] FLD_PLACEMENT = 3'd0;
  localparam logic [2:0] FLD_SIDE      = 3'd1;
  localparam logic [2:0] FLD_CASTLE    = 3'd2;
  localparam logic [2:0] FLD_PASSANT   = 3'd3;

  // Characters with a meaning in the string
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_W = 8'h77;
  localparam logic [7:0] CH_K_WHITE = 8'h4B;
  localparam logic [7:0] CH_Q_WHITE = 8'h51;
  localparam logic [7:0] CH_K_BLACK = 8'h6B;
  localparam logic [7:0] CH_Q_BLACK = 8'h71;

  // Bias subtracted from the en passant file and rank bytes ('a' and '1')
  localparam logic signed [10:0] FILE_BIAS = 11'sd97;
  localparam logic signed [10:0] RANK_BIAS = 11'sd49;

  // Castling right bits
  localparam int unsigned CR_WK = 0;
  localparam int unsigned CR_WQ = 1;
  localparam int unsigned CR_BK = 2;
  localparam int unsigned CR_BQ = 3;

  // Board order of the results
  typedef enum logic [3:0] {
    BRD_BLACK_KING, BRD_BLACK_QUEEN, BRD_BLACK_ROOK, BRD_BLACK_BISHOP,
    BRD_BLACK_KNIGHT, BRD_BLACK_PAWN, BRD_WHITE_KING, BRD_WHITE_QUEEN,
    BRD_WHITE_ROOK, BRD_WHITE_BISHOP, BRD_WHITE_KNIGHT, BRD_WHITE_PAWN,
    BRD_ALL_WHITE, BRD_ALL_BLACK
  } board_id_t;

  typedef logic [NUM_BOARDS-1:0][63:0] boards_t;

  // Everything a snapshot of the position holds
  typedef struct packed {
    boards_t    boards;
    logic       black_to_move;
    logic [3:0] castle;
    logic [6:0] ep_square;
  } position_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } piece_sel_t;

  // Board index of a piece letter, hit low for any other byte
  function automatic piece_sel_t piece_index(input logic [7:0] c);
    piece_sel_t r;
    r.hit = 1'b1;
    case (c)
      8'h6B:   r.idx = BRD_BLACK_KING;    // k
      8'h71:   r.idx = BRD_BLACK_QUEEN;   // q
      8'h72:   r.idx = BRD_BLACK_ROOK;    // r
      8'h62:   r.idx = BRD_BLACK_BISHOP;  // b
      8'h6E:   r.idx = BRD_BLACK_KNIGHT;  // n
      8'h70:   r.idx = BRD_BLACK_PAWN;    // p
      8'h4B:   r.idx = BRD_WHITE_KING;    // K
      8'h51:   r.idx = BRD_WHITE_QUEEN;   // Q
      8'h52:   r.idx = BRD_WHITE_ROOK;    // R
      8'h42:   r.idx = BRD_WHITE_BISHOP;  // B
      8'h4E:   r.idx = BRD_WHITE_KNIGHT;  // N
      8'h50:   r.idx = BRD_WHITE_PAWN;    // P
      default: begin
        r.hit = 1'b0;
        r.idx = BRD_BLACK_KING;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fen_position_parser.sv =====
// FEN position parser: one byte per cycle in unless stalled, the 14 occupancy boards out after the last byte.
// A FEN string enters one byte per request, one request per cycle unless in_stall holds. Each byte
// goes into an input register and is parsed from there by short logic into the position registers.
// A byte flagged last also copies the finished position into an output snapshot, from which
// 14 results (boards 0 to 13, each with side to move, castling rights and en passant square) leave one
// per cycle while the out side does not stall. Bytes of the next string are taken during that
// burst; only a further last byte waits in the input register until the last result of the
// previous burst has been delivered. A last byte passes the input and snapshot registers before its first result.
`default_nettype none
module fen_position_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_first_of_string,
  input  wire logic        in_last_of_string,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_board_select,
  output logic [63:0]      out_board_bits,
  output logic             out_side_to_move,
  output logic [3:0]       out_castle_rights,
  output logic [6:0]       out_ep_square,
  output logic             out_last_board
);

  logic               in_vld_r;
  logic [7:0]         in_char_r;
  logic               in_first_r;
  logic               in_last_r;
  logic               busy;
  logic               go;
  logic               load;
  fpp_pkg::position_t pos_nxt;

  // A last byte holds while the previous burst drains
  assign in_stall = in_vld_r && in_last_r && busy;
  assign go       = in_vld_r && !in_stall;
  assign load     = go && in_last_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r  <= in_char_byte;
      in_first_r <= in_first_of_string;
      in_last_r  <= in_last_of_string;
    end
  end

  fpp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (go),
    .char_byte       (in_char_r),
    .first_of_string (in_first_r),
    .last_of_string  (in_last_r),
    .pos_nxt         (pos_nxt)
  );

  fpp_emitter u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .pos               (pos_nxt),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_board_select  (out_board_select),
    .out_board_bits    (out_board_bits),
    .out_side_to_move  (out_side_to_move),
    .out_castle_rights (out_castle_rights),
    .out_ep_square     (out_ep_square),
    .out_last_board    (out_last_board)
  );

endmodule
`default_nettype wire

// ===== hdl/fpp_parser.sv =====
// Parser state and the per-byte update of the position.
`default_nettype none
module fpp_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [7:0]       char_byte,
  input  wire logic             first_of_string,
  input  wire logic             last_of_string,
  output fpp_pkg::position_t    pos_nxt
);

  fpp_pkg::boards_t boards_r, boards_nxt;
  logic [2:0]       field_r, field_nxt;
  logic [7:0]       cursor_r, cursor_nxt;
  logic             stm_r, stm_nxt;
  logic [3:0]       castle_r, castle_nxt;
  logic [6:0]       ep_r, ep_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       held_r, held_nxt;

  // Square from the held file byte and the rank byte
  logic signed [10:0] file_d, rank_d;
  logic signed [13:0] sq;
  logic               sq_ok;

  assign file_d = $signed({3'b000, held_r}) - fpp_pkg::FILE_BIAS;
  assign rank_d = $signed({3'b000, char_byte}) - fpp_pkg::RANK_BIAS;
  assign sq     = {{3{file_d[10]}}, file_d} + ({{3{rank_d[10]}}, rank_d} <<< 3);
  assign sq_ok  = (sq[13:6] == 8'd0);

  // Next state for one byte
  always_comb begin
    fpp_pkg::piece_sel_t pc;
    logic [63:0]         mask;
    pc = fpp_pkg::piece_index(char_byte);
    mask = 64'd1 << cursor_r[5:0];
    if (first_of_string) begin
      boards_nxt = '0;
      field_nxt  = fpp_pkg::FLD_PLACEMENT;
      cursor_nxt = fpp_pkg::START_SQUARE;
      stm_nxt    = 1'b0;
      castle_nxt = 4'd0;
      ep_nxt     = fpp_pkg::NO_SQUARE;
      pend_nxt   = 1'b0;
      held_nxt   = 8'd0;
      mask       = 64'd1 << fpp_pkg::START_SQUARE[5:0];
    end else begin
      boards_nxt = boards_r;
      field_nxt  = field_r;
      cursor_nxt = cursor_r;
      stm_nxt    = stm_r;
      castle_nxt = castle_r;
      ep_nxt     = ep_r;
      pend_nxt   = pend_r;
      held_nxt   = held_r;
    end

    if (pend_nxt) begin
      // rank byte of the en passant square
      ep_nxt   = sq_ok ? sq[6:0] : fpp_pkg::NO_SQUARE;
      pend_nxt = 1'b0;
    end else if (char_byte == fpp_pkg::CH_SPACE) begin
      if (field_nxt < fpp_pkg::FIELD_MAX) begin
        field_nxt = field_nxt + 3'd1;
      end
    end else begin
      case (field_nxt)
        fpp_pkg::FLD_PLACEMENT: begin
          if (char_byte inside {[fpp_pkg::CH_ZERO:fpp_pkg::CH_NINE]}) begin
            cursor_nxt = cursor_nxt + {4'd0, char_byte[3:0]};
          end else if (char_byte == fpp_pkg::CH_SLASH) begin
            cursor_nxt = cursor_nxt - fpp_pkg::ROW_STEP;
          end else begin
            if (cursor_nxt[7:6] == 2'b00) begin
              if (pc.hit) begin
                boards_nxt[pc.idx] = boards_nxt[pc.idx] | mask;
              end
              if (char_byte inside {[fpp_pkg::CH_UPPER_A:fpp_pkg::CH_UPPER_Z]}) begin
                boards_nxt[fpp_pkg::WHITE_BOARD] = boards_nxt[fpp_pkg::WHITE_BOARD] | mask;
              end else begin
                boards_nxt[fpp_pkg::BLACK_BOARD] = boards_nxt[fpp_pkg::BLACK_BOARD] | mask;
              end
            end
            cursor_nxt = cursor_nxt + 8'd1;
          end
        end
        fpp_pkg::FLD_SIDE: stm_nxt = (char_byte != fpp_pkg::CH_LOWER_W);
        fpp_pkg::FLD_CASTLE: begin
          if (char_byte == fpp_pkg::CH_K_WHITE)      castle_nxt[fpp_pkg::CR_WK] = 1'b1;
          else if (char_byte == fpp_pkg::CH_Q_WHITE) castle_nxt[fpp_pkg::CR_WQ] = 1'b1;
          else if (char_byte == fpp_pkg::CH_K_BLACK) castle_nxt[fpp_pkg::CR_BK] = 1'b1;
          else if (char_byte == fpp_pkg::CH_Q_BLACK) castle_nxt[fpp_pkg::CR_BQ] = 1'b1;
        end
        fpp_pkg::FLD_PASSANT: begin
          if (char_byte == fpp_pkg::CH_DASH) begin
            ep_nxt = fpp_pkg::NO_SQUARE;
          end else begin
            held_nxt = char_byte;
            pend_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // string ends with the rank still missing
    if (last_of_string && pend_nxt) begin
      ep_nxt   = fpp_pkg::NO_SQUARE;
      pend_nxt = 1'b0;
    end
  end

  // Position seen by the emitter when this byte closes the string
  always_comb begin
    pos_nxt.boards        = boards_nxt;
    pos_nxt.black_to_move = stm_nxt;
    pos_nxt.castle        = castle_nxt;
    pos_nxt.ep_square     = ep_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boards_r <= '0;
      field_r  <= fpp_pkg::FLD_PLACEMENT;
      cursor_r <= fpp_pkg::START_SQUARE;
      stm_r    <= 1'b0;
      castle_r <= 4'd0;
      ep_r     <= fpp_pkg::NO_SQUARE;
      pend_r   <= 1'b0;
      held_r   <= 8'd0;
    end else if (go) begin
      boards_r <= boards_nxt;
      field_r  <= field_nxt;
      cursor_r <= cursor_nxt;
      stm_r    <= stm_nxt;
      castle_r <= castle_nxt;
      ep_r     <= ep_nxt;
      pend_r   <= pend_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fpp_emitter.sv =====
// Snapshot of a finished position and its 14-result output sequence.
`default_nettype none
`include "fen_position_parser_assert.svh"
module fpp_emitter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire fpp_pkg::position_t pos,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             out_board_select,
  output logic [63:0]            out_board_bits,
  output logic                   out_side_to_move,
  output logic [3:0]             out_castle_rights,
  output logic [6:0]             out_ep_square,
  output logic                   out_last_board
);

  logic             busy_r;
  logic [3:0]       sel_r;
  fpp_pkg::boards_t boards_r;
  logic             stm_r;
  logic [3:0]       castle_r;
  logic [6:0]       ep_r;
  logic             out_acc;
  logic             at_last;

  assign out_acc = busy_r && !out_stall;
  assign at_last = (sel_r == fpp_pkg::LAST_BOARD);

  // Control: burst of 14 results after each load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= 4'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      sel_r  <= 4'd0;
    end else if (out_acc) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        sel_r <= sel_r + 4'd1;
      end
    end
  end

  // Payload: boards shift down one place per delivered result before the last
  always_ff @(posedge clk) begin
    if (load) begin
      boards_r <= pos.boards;
      stm_r    <= pos.black_to_move;
      castle_r <= pos.castle;
      ep_r     <= pos.ep_square;
    end else if (out_acc && !at_last) begin
      boards_r <= {64'd0, boards_r[fpp_pkg::NUM_BOARDS-1:1]};
    end
  end

  assign busy              = busy_r;
  assign out_valid         = busy_r;
  assign out_board_select  = sel_r;
  assign out_board_bits    = boards_r[0];
  assign out_side_to_move  = stm_r;
  assign out_castle_rights = castle_r;
  assign out_ep_square     = ep_r;
  assign out_last_board    = at_last;

  // A new snapshot never lands on a burst still in flight
  `FPP_ASSERT_NEVER(a_no_load_busy, load && busy_r && !(out_acc && at_last))
  // The final accepted result ends the burst unless a new one loads
  `FPP_ASSERT(a_burst_ends, (out_acc && at_last && !load) |=> !busy_r)
  // Select walks up by one on every delivered result but the last
  `FPP_ASSERT(a_sel_step, (out_acc && !at_last && !load) |=> (sel_r == $past(sel_r) + 4'd1))
  // Select stays within the 14 boards while showing results
  `FPP_ASSERT_NEVER(a_sel_range, busy_r && (sel_r > fpp_pkg::LAST_BOARD))

endmodule
`default_nettype wire
